// ----- rtl/framed_zigzag_varint_decoder_defines.svh -----
// Assertion macros shared by the decoder RTL.
`ifndef FRAMED_ZIGZAG_VARINT_DECODER_DEFINES_SVH
`define FRAMED_ZIGZAG_VARINT_DECODER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define FZVD_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define FZVD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/fzvd_pkg.sv -----
`timescale 1ns / 1ps

package fzvd_pkg;

    localparam int VALUE_BITS_DEF = 64;
    localparam int BYTE_W         = 8;
    localparam int FIELD_W        = 64;
    localparam int REC_W          = 16;
    localparam int TDATA_W        = FIELD_W + REC_W;
    localparam int TUSER_W        = 2;
    localparam int GroupBits      = 7;
    localparam int GP_W           = 4;

    localparam logic [BYTE_W-1:0]    MARKER_BYTE = 8'hFF;
    localparam int                   CONT_BIT    = 7;
    localparam int                   LONG_BIT    = 1;
    localparam logic [GP_W-1:0]      GP_MAX      = 4'd15;
    localparam logic [REC_W-1:0]     REC_MAX     = 16'hFFFF;

    typedef enum logic [3:0] {
        PH_MARKER = 4'b0001,
        PH_HEADER = 4'b0010,
        PH_VARINT = 4'b0100,
        PH_HALTED = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [REC_W-1:0]          record_number;
        logic signed [FIELD_W-1:0] field_value;
        logic                      overflow;
        logic                      is_long;
        logic                      last_field;
    } result_t;

endpackage

// ----- rtl/framed_zigzag_varint_decoder.sv -----
`timescale 1ns / 1ps
`include "framed_zigzag_varint_decoder_defines.svh"

// Framed zigzag varint decoder. Takes one stream byte per cycle on the s_ side
// while s_tready is high: every byte is absorbed by a single registered state
// update (marker check, header capture, or merge of one seven-bit group into
// the accumulator). A field's result is registered into the output register, or
// into the skid register while the output register is held, when its final
// varint byte is taken. A two-entry output buffer (output register plus skid
// register) keeps s_tready high for one extra result while m_tready is low. A
// missing 0xFF record marker halts decoding; bytes are then consumed and dropped
// until reset. Values are accumulated at VALUE_BITS and sign-extended to 64 bits.
module framed_zigzag_varint_decoder #(
    parameter int VALUE_BITS = fzvd_pkg::VALUE_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [fzvd_pkg::BYTE_W-1:0]  s_tdata,   // [7:0] data_byte
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [fzvd_pkg::TDATA_W-1:0] m_tdata,   // [63:0] field_value, [79:64] record_number
    output logic                         m_tlast,   // last_field
    output logic [fzvd_pkg::TUSER_W-1:0] m_tuser    // [0] is_long, [1] overflow
);
    import fzvd_pkg::*;

    phase_t                  phase_reg, phase_next;
    logic [VALUE_BITS-1:0]   acc_reg, acc_next;
    logic [GP_W-1:0]         gp_reg, gp_next;
    logic                    long_reg, long_next;
    logic                    more_reg, more_next;
    logic [REC_W-1:0]        rec_reg, rec_next;
    logic                    ovf_reg, ovf_next;

    result_t                 out_reg, skid_reg, gen_result;
    logic                    out_valid_reg, skid_valid_reg;
    logic                    gen_valid;
    logic                    s_fire;
    logic                    out_free;

    logic [GroupBits-1:0]    payload;
    logic [VALUE_BITS-1:0]   lane_bits;
    logic [VALUE_BITS-1:0]   acc_merged;
    logic [GroupBits-1:0]    drop_mask;
    logic                    ovf_merged;
    logic [6:0]              shift;
    logic [VALUE_BITS-1:0]   zz;

    assign s_tready = !skid_valid_reg;
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    assign payload = s_tdata[GroupBits-1:0];
    assign shift   = 7'({gp_reg, 3'b000}) - 7'(gp_reg);

    // Each accumulator bit belongs to one fixed group and one bit within it.
    for (genvar gi = 0; gi < VALUE_BITS; gi++) begin : g_lane
        assign lane_bits[gi] = payload[gi % GroupBits] && (gp_reg == GP_W'(gi / GroupBits));
    end

    // Payload bits landing at or above VALUE_BITS are dropped.
    for (genvar bi = 0; bi < GroupBits; bi++) begin : g_drop
        assign drop_mask[bi] = (8'(shift) + 8'(bi)) >= 8'(VALUE_BITS);
    end

    assign acc_merged = acc_reg | lane_bits;
    assign ovf_merged = ovf_reg || |(payload & drop_mask);
    assign zz         = {1'b0, acc_merged[VALUE_BITS-1:1]} ^ {VALUE_BITS{acc_merged[0]}};

    always_comb begin
        gen_result.record_number = rec_reg;
        gen_result.field_value   = FIELD_W'($signed(zz));
        gen_result.overflow      = ovf_merged;
        gen_result.is_long       = long_reg;
        gen_result.last_field    = !more_reg;
    end

    always_comb begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        gp_next    = gp_reg;
        long_next  = long_reg;
        more_next  = more_reg;
        rec_next   = rec_reg;
        ovf_next   = ovf_reg;
        gen_valid  = 1'b0;
        if (s_fire) begin
            unique case (phase_reg)
                PH_MARKER: begin
                    if (s_tdata == MARKER_BYTE) begin
                        if (rec_reg != REC_MAX) begin
                            rec_next = rec_reg + 1'b1;
                        end
                        phase_next = PH_HEADER;
                    end else begin
                        phase_next = PH_HALTED;
                    end
                end
                PH_HEADER: begin
                    more_next  = s_tdata[CONT_BIT];
                    long_next  = s_tdata[LONG_BIT];
                    acc_next   = '0;
                    gp_next    = '0;
                    ovf_next   = 1'b0;
                    phase_next = PH_VARINT;
                end
                PH_VARINT: begin
                    acc_next = acc_merged;
                    ovf_next = ovf_merged;
                    if (gp_reg != GP_MAX) begin
                        gp_next = gp_reg + 1'b1;
                    end
                    if (!s_tdata[CONT_BIT]) begin
                        gen_valid  = 1'b1;
                        phase_next = more_reg ? PH_HEADER : PH_MARKER;
                    end
                end
                PH_HALTED: begin
                    phase_next = PH_HALTED;
                end
                default: begin
                    phase_next = PH_HALTED;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_MARKER;
            acc_reg   <= '0;
            gp_reg    <= '0;
            long_reg  <= 1'b0;
            more_reg  <= 1'b0;
            rec_reg   <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            gp_reg    <= gp_next;
            long_reg  <= long_next;
            more_reg  <= more_next;
            rec_reg   <= rec_next;
            ovf_reg   <= ovf_next;
        end
    end

    // Output register with one skid entry behind it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_tready) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end else if (out_free) begin
            out_valid_reg <= gen_valid;
        end else if (gen_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_tready) begin
                out_reg <= skid_reg;
            end
        end else if (out_free) begin
            if (gen_valid) begin
                out_reg <= gen_result;
            end
        end else if (gen_valid) begin
            skid_reg <= gen_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.record_number, out_reg.field_value};
    assign m_tlast  = out_reg.last_field;
    assign m_tuser  = {out_reg.overflow, out_reg.is_long};

    `FZVD_ASSERT_NOW(a_skid_behind_out, aclk, aresetn, skid_valid_reg, out_valid_reg,
        "skid entry held while output register empty")

    `FZVD_ASSERT_NEXT(a_halt_sticks, aclk, aresetn, phase_reg == PH_HALTED,
        phase_reg == PH_HALTED, "decoder left halted state without reset")

    `FZVD_ASSERT_NEXT(a_rec_monotonic, aclk, aresetn, 1'b1,
        rec_reg >= $past(rec_reg), "record counter decreased")

    `FZVD_ASSERT_NOW(a_result_from_varint, aclk, aresetn, gen_valid,
        phase_reg == PH_VARINT && s_fire, "result produced outside varint phase")

endmodule
